### sv/cmdfc_pkg.sv
package cmdfc_pkg;

	localparam int BUFFER_BYTES_DEF = 64;
	localparam int FRAME_OVERHEAD   = 9;
	localparam int RESP_BYTES       = 11;
	localparam int RESP_CNT_W       = $clog2(RESP_BYTES);

	localparam logic [RESP_CNT_W-1:0] RESP_LAST = RESP_CNT_W'(RESP_BYTES - 1);

	localparam logic [7:0] UPDATE_COMMAND = 8'hB5;
	localparam logic [7:0] RESP_BYTE_3    = 8'h02;
	localparam logic [7:0] RESP_BYTE_4    = 8'h00;
	localparam logic [7:0] RESP_BYTE_5    = 8'hFD;
	localparam logic [7:0] RESP_BYTE_6    = 8'hFF;

	typedef enum logic [2:0] {
		CFG_HEADER_ONE   = 3'd0,
		CFG_HEADER_TWO   = 3'd1,
		CFG_HEADER_THREE = 3'd2,
		CFG_TAIL         = 3'd3,
		CFG_LENGTH_LIMIT = 3'd4,
		CFG_CSUM_CODE    = 3'd5,
		CFG_UNSUP_CODE   = 3'd6
	} cfg_index_t;

	localparam logic [7:0] RST_HEADER_ONE   = 8'hAA;
	localparam logic [7:0] RST_HEADER_TWO   = 8'h55;
	localparam logic [7:0] RST_HEADER_THREE = 8'hA5;
	localparam logic [7:0] RST_TAIL         = 8'h5A;
	localparam logic [6:0] RST_LENGTH_LIMIT = 7'd53;
	localparam logic [7:0] RST_CSUM_CODE    = 8'h01;
	localparam logic [7:0] RST_UNSUP_CODE   = 8'h02;

	typedef struct packed {
		logic [7:0] header_one;
		logic [7:0] header_two;
		logic [7:0] header_three;
		logic [7:0] tail;
		logic [6:0] length_limit;
		logic [7:0] csum_code;
		logic [7:0] unsup_code;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] cmd;
		logic [7:0] code;
	} resp_t;

endpackage

### sv/cmdfc_parser.sv
module cmdfc_parser #(
	parameter int BUFFER_BYTES = cmdfc_pkg::BUFFER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmdfc_pkg::cfg_t   cfg,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	input  logic              packet_start,
	output cmdfc_pkg::resp_t  resp
);

	localparam int POS_W = $clog2(BUFFER_BYTES);
	localparam logic [16:0] MAX_LEN = 17'(BUFFER_BYTES - cmdfc_pkg::FRAME_OVERHEAD);

	logic [POS_W-1:0] pos_q;
	logic [15:0]      len_q;
	logic [7:0]       inv_lo_q;
	logic [7:0]       sum_q;
	logic [7:0]       cmd_q;
	logic [7:0]       rsum_q;
	logic             alive_q;

	logic [POS_W-1:0] pos_e;
	logic [15:0]      len_e;
	logic [7:0]       sum_e;
	logic [7:0]       cmd_e;
	logic [7:0]       rsum_e;
	logic             alive_e;

	logic [POS_W-1:0] pos_d;
	logic [15:0]      len_d;
	logic [7:0]       inv_lo_d;
	logic [7:0]       sum_d;
	logic [7:0]       cmd_d;
	logic [7:0]       rsum_d;
	logic             alive_d;

	logic [15:0]      inv_full;
	logic [POS_W:0]   pos_x;
	logic [POS_W:0]   csum_pos;
	logic [POS_W:0]   tail_pos;

	always_comb begin
		alive_e = packet_start | alive_q;
		pos_e   = packet_start ? '0 : pos_q;
		len_e   = packet_start ? '0 : len_q;
		sum_e   = packet_start ? '0 : sum_q;
		cmd_e   = packet_start ? '0 : cmd_q;
		rsum_e  = packet_start ? '0 : rsum_q;

		inv_full = {rx_byte, inv_lo_q};
		pos_x    = {1'b0, pos_e};
		csum_pos = (POS_W+1)'(7) + {1'b0, len_e[POS_W-1:0]};
		tail_pos = (POS_W+1)'(8) + {1'b0, len_e[POS_W-1:0]};

		pos_d    = pos_e + POS_W'(1);
		len_d    = len_e;
		inv_lo_d = packet_start ? '0 : inv_lo_q;
		sum_d    = sum_e;
		cmd_d    = cmd_e;
		rsum_d   = rsum_e;
		alive_d  = alive_e;
		resp     = '0;
		resp.cmd = cmd_e;

		case (pos_e)
			POS_W'(0): if (rx_byte != cfg.header_one) alive_d = 1'b0;
			POS_W'(1): if (rx_byte != cfg.header_two) alive_d = 1'b0;
			POS_W'(2): if (rx_byte != cfg.header_three) alive_d = 1'b0;
			POS_W'(3): len_d = {8'h00, rx_byte};
			POS_W'(4): len_d = {rx_byte, len_e[7:0]};
			POS_W'(5): inv_lo_d = rx_byte;
			POS_W'(6): begin
				if ((~inv_full) != len_e
					|| len_e >= {9'd0, cfg.length_limit}
					|| {1'b0, len_e} > MAX_LEN)
					alive_d = 1'b0;
			end
			default: begin
				if (pos_e == POS_W'(7)) cmd_d = rx_byte;
				if (pos_x < csum_pos) sum_d = sum_e + rx_byte;
				if (pos_x == csum_pos) rsum_d = rx_byte;
				if (pos_x == tail_pos) begin
					alive_d = 1'b0;
					if (rx_byte == cfg.tail) begin
						if (sum_e != rsum_e) begin
							resp.valid = 1'b1;
							resp.code  = cfg.csum_code;
						end else if (cmd_e != cmdfc_pkg::UPDATE_COMMAND) begin
							resp.valid = 1'b1;
							resp.code  = cfg.unsup_code;
						end
					end
				end
			end
		endcase

		if (!alive_e || !accept) resp.valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q  <= 1'b0;
			pos_q    <= '0;
			len_q    <= '0;
			inv_lo_q <= '0;
			sum_q    <= '0;
			cmd_q    <= '0;
			rsum_q   <= '0;
		end else if (accept && alive_e) begin
			alive_q  <= alive_d;
			pos_q    <= pos_d;
			len_q    <= len_d;
			inv_lo_q <= inv_lo_d;
			sum_q    <= sum_d;
			cmd_q    <= cmd_d;
			rsum_q   <= rsum_d;
		end
	end

endmodule

### sv/cmdfc_tx.sv
module cmdfc_tx (
	input  logic             clk,
	input  logic             arst_n,
	input  cmdfc_pkg::cfg_t  cfg,
	input  cmdfc_pkg::resp_t new_resp,
	output logic             pend_full,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tuser
);

	logic                             pend_valid_q;
	logic [7:0]                       pend_cmd_q;
	logic [7:0]                       pend_code_q;
	logic                             out_valid_q;
	logic [cmdfc_pkg::RESP_CNT_W-1:0] cnt_q;
	logic [7:0]                       cmd_q;
	logic [7:0]                       code_q;
	logic                             at_last;
	logic                             free;

	assign at_last   = cnt_q == cmdfc_pkg::RESP_LAST;
	assign free      = !out_valid_q || (m_tready && at_last);
	assign pend_full = pend_valid_q;
	assign m_tvalid  = out_valid_q;
	assign m_tuser   = at_last;

	always_comb begin
		case (cnt_q)
			4'd0:    m_tdata = cfg.header_one;
			4'd1:    m_tdata = cfg.header_two;
			4'd2:    m_tdata = cfg.header_three;
			4'd3:    m_tdata = cmdfc_pkg::RESP_BYTE_3;
			4'd4:    m_tdata = cmdfc_pkg::RESP_BYTE_4;
			4'd5:    m_tdata = cmdfc_pkg::RESP_BYTE_5;
			4'd6:    m_tdata = cmdfc_pkg::RESP_BYTE_6;
			4'd7:    m_tdata = cmd_q;
			4'd8:    m_tdata = code_q;
			4'd9:    m_tdata = cmd_q + code_q;
			4'd10:   m_tdata = cfg.tail;
			default: m_tdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (new_resp.valid) begin
				pend_valid_q <= 1'b1;
			end else if (free && pend_valid_q) begin
				pend_valid_q <= 1'b0;
			end
			if (free) begin
				out_valid_q <= pend_valid_q;
				cnt_q       <= '0;
			end else if (m_tready) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (new_resp.valid) begin
			pend_cmd_q  <= new_resp.cmd;
			pend_code_q <= new_resp.code;
		end
		if (free && pend_valid_q) begin
			cmd_q  <= pend_cmd_q;
			code_q <= pend_code_q;
		end
	end

endmodule

### sv/command_frame_checker_responder_top.sv
// channel  direction  tdata         tuser          width
// s_       in         rx_byte[7:0]  packet_start   8 + 1
// m_       out        tx_byte[7:0]  tx_last        8 + 1
// cfg_     in         cfg_wdata     -              3-bit index, 8-bit data
//
// One rx beat is parsed per cycle while s_tready is high; the frame state updates at the accept edge.
// A response is 11 m_ beats, paced by the output byte counter.
// One response may wait in a holding slot; s_tready drops while it is full.
// Reset clears the frame state and loads the register defaults.
module command_frame_checker_responder_top #(
	parameter int BUFFER_BYTES = cmdfc_pkg::BUFFER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       s_tuser,   // [0] packet_start
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] tx_byte
	output logic       m_tuser,   // [0] tx_last
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	cmdfc_pkg::cfg_t  cfg_q;
	cmdfc_pkg::resp_t resp;
	logic             pend_full;
	logic             accept;

	assign s_tready = !pend_full;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_one   <= cmdfc_pkg::RST_HEADER_ONE;
			cfg_q.header_two   <= cmdfc_pkg::RST_HEADER_TWO;
			cfg_q.header_three <= cmdfc_pkg::RST_HEADER_THREE;
			cfg_q.tail         <= cmdfc_pkg::RST_TAIL;
			cfg_q.length_limit <= cmdfc_pkg::RST_LENGTH_LIMIT;
			cfg_q.csum_code    <= cmdfc_pkg::RST_CSUM_CODE;
			cfg_q.unsup_code   <= cmdfc_pkg::RST_UNSUP_CODE;
		end else if (cfg_we) begin
			case (cfg_index)
				cmdfc_pkg::CFG_HEADER_ONE:   cfg_q.header_one   <= cfg_wdata;
				cmdfc_pkg::CFG_HEADER_TWO:   cfg_q.header_two   <= cfg_wdata;
				cmdfc_pkg::CFG_HEADER_THREE: cfg_q.header_three <= cfg_wdata;
				cmdfc_pkg::CFG_TAIL:         cfg_q.tail         <= cfg_wdata;
				cmdfc_pkg::CFG_LENGTH_LIMIT: cfg_q.length_limit <= cfg_wdata[6:0];
				cmdfc_pkg::CFG_CSUM_CODE:    cfg_q.csum_code    <= cfg_wdata;
				cmdfc_pkg::CFG_UNSUP_CODE:   cfg_q.unsup_code   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	cmdfc_parser #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.accept       (accept),
		.rx_byte      (s_tdata),
		.packet_start (s_tuser),
		.resp         (resp)
	);

	cmdfc_tx u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.new_resp  (resp),
		.pend_full (pend_full),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
